// ----- design/deq_pkg.sv -----
// Shared types, codes and widths for the indexed double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int ACT_W  = 3;
    localparam int WORD_W = 64;
    localparam int POS_W  = 10;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 11;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_BACK  = 3'd0,
        ACT_POP_BACK   = 3'd1,
        ACT_PUSH_FRONT = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_READ_FRONT = 3'd4,
        ACT_READ_BACK  = 3'd5,
        ACT_READ_POS   = 3'd6
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } t_state;

    typedef enum logic [2:0] {
        OFF_ZERO     = 3'd0,
        OFF_COUNT    = 3'd1,
        OFF_COUNT_M1 = 3'd2,
        OFF_ONE      = 3'd3,
        OFF_LAST     = 3'd4,
        OFF_POS      = 3'd5
    } t_offset;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    typedef struct packed {
        logic    accept;
        logic    wr_en;
        logic    rd_en;
        t_offset off_sel;
        logic    head_load;
        t_cnt_op cnt_op;
        logic    res_valid;
        t_status res_status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_ok;
    } t_flags;

endpackage

// ----- design/double_ended_queue_indexed.sv -----
// Top level of the indexed double-ended queue of signed 64-bit words.
// Each request (push or pop at either end, read front, read back, or read at a position
// from the front) is registered when taken, and its result appears in the output register
// on the next cycle. A new request is accepted in the same cycle that the previous result
// is taken, so with the output side always ready the queue sustains one request per
// cycle; the single-port ring memory with its registered read sets that figure.
// Results stay in the output register while the output side stalls, and no further
// request is taken until the result leaves. No clearing pass is needed after reset.
module double_ended_queue_indexed
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic        [ACT_W-1:0]  i_action,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic        [POS_W-1:0]  i_position,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [WORD_W-1:0] o_data,
    output logic                     o_data_valid,
    output logic        [STAT_W-1:0] o_status,
    output logic        [OCC_W-1:0]  o_occupancy
);

    t_cmd   cmd;
    t_flags flags;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_flags     (flags),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_flags      (flags),
        .o_data       (o_data),
        .o_data_valid (o_data_valid),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

// ----- design/deq_ctrl.sv -----
// Controller: handshake state machine and action decode for the queue.
module deq_ctrl
    import deq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    input  logic             i_out_ready,
    input  t_flags           i_flags,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_out_valid = (r_state == S_RESULT);
        o_in_ready  = (r_state == S_IDLE) || i_out_ready;
        accept      = i_in_valid && o_in_ready;

        priority if (accept) begin
            n_state = S_RESULT;
        end else if ((r_state == S_RESULT) && i_out_ready) begin
            n_state = S_IDLE;
        end else begin
            n_state = r_state;
        end

        o_cmd            = '0;
        o_cmd.accept     = accept;
        o_cmd.off_sel    = OFF_ZERO;
        o_cmd.cnt_op     = CNT_HOLD;
        o_cmd.res_status = ST_OK;

        unique case (i_action)
            ACT_PUSH_BACK: begin
                if (i_flags.full) begin
                    o_cmd.res_status = ST_FULL;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.off_sel = OFF_COUNT;
                    o_cmd.cnt_op  = CNT_INC;
                end
            end
            ACT_POP_BACK: begin
                if (i_flags.empty) begin
                    o_cmd.res_status = ST_EMPTY;
                end else begin
                    o_cmd.cnt_op = CNT_DEC;
                end
            end
            ACT_PUSH_FRONT: begin
                if (i_flags.full) begin
                    o_cmd.res_status = ST_FULL;
                end else begin
                    o_cmd.wr_en     = 1'b1;
                    o_cmd.off_sel   = OFF_LAST;
                    o_cmd.head_load = 1'b1;
                    o_cmd.cnt_op    = CNT_INC;
                end
            end
            ACT_POP_FRONT: begin
                if (i_flags.empty) begin
                    o_cmd.res_status = ST_EMPTY;
                end else begin
                    o_cmd.off_sel   = OFF_ONE;
                    o_cmd.head_load = 1'b1;
                    o_cmd.cnt_op    = CNT_DEC;
                end
            end
            ACT_READ_FRONT: begin
                if (i_flags.empty) begin
                    o_cmd.res_status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.off_sel   = OFF_ZERO;
                    o_cmd.res_valid = 1'b1;
                end
            end
            ACT_READ_BACK: begin
                if (i_flags.empty) begin
                    o_cmd.res_status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.off_sel   = OFF_COUNT_M1;
                    o_cmd.res_valid = 1'b1;
                end
            end
            ACT_READ_POS: begin
                if (!i_flags.pos_ok) begin
                    o_cmd.res_status = ST_RANGE;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.off_sel   = OFF_POS;
                    o_cmd.res_valid = 1'b1;
                end
            end
            default: begin
                o_cmd.res_status = ST_OK;
            end
        endcase
    end

endmodule

// ----- design/deq_dp.sv -----
// Datapath: ring memory, head pointer, entry count and result registers.
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic        [POS_W-1:0]  i_position,
    output t_flags                   o_flags,
    output logic signed [WORD_W-1:0] o_data,
    output logic                     o_data_valid,
    output logic        [STAT_W-1:0] o_status,
    output logic        [OCC_W-1:0]  o_occupancy
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;
    logic        [PTR_W-1:0]  r_head;
    logic        [PTR_W-1:0]  n_head;
    logic        [CNT_W-1:0]  r_count;
    logic        [CNT_W-1:0]  n_count;
    logic                     r_res_valid;
    t_status                  r_res_status;
    logic        [OCC_W-1:0]  r_occ;
    logic        [SUM_W-1:0]  offset;
    logic        [SUM_W-1:0]  sum;
    logic        [SUM_W-1:0]  wrapped;
    logic        [PTR_W-1:0]  addr;

    always_comb begin
        unique case (i_cmd.off_sel)
            OFF_ZERO:     offset = '0;
            OFF_COUNT:    offset = SUM_W'(r_count);
            OFF_COUNT_M1: offset = SUM_W'(r_count) - SUM_W'(1);
            OFF_ONE:      offset = SUM_W'(1);
            OFF_LAST:     offset = SUM_W'(DEPTH - 1);
            OFF_POS:      offset = SUM_W'(i_position);
            default:      offset = '0;
        endcase

        sum     = SUM_W'(r_head) + offset;
        wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
        addr    = wrapped[PTR_W-1:0];

        o_flags.empty  = (r_count == '0);
        o_flags.full   = (r_count == CNT_W'(DEPTH));
        o_flags.pos_ok = (SUM_W'(i_position) < SUM_W'(r_count));

        n_head = (i_cmd.accept && i_cmd.head_load) ? addr : r_head;

        n_count = r_count;
        if (i_cmd.accept) begin
            unique case (i_cmd.cnt_op)
                CNT_INC:  n_count = r_count + CNT_W'(1);
                CNT_DEC:  n_count = r_count - CNT_W'(1);
                CNT_HOLD: n_count = r_count;
                default:  n_count = r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_cmd.wr_en) begin
            r_mem[addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_cmd.rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_res_valid  <= 1'b0;
            r_res_status <= ST_OK;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.accept) begin
                r_res_valid  <= i_cmd.res_valid;
                r_res_status <= i_cmd.res_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_occ <= OCC_W'(n_count);
        end
    end

    assign o_data       = r_res_valid ? r_rd_data : '0;
    assign o_data_valid = r_res_valid;
    assign o_status     = r_res_status;
    assign o_occupancy  = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("Entry count exceeds the queue depth.");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && i_cmd.cnt_op == CNT_INC)
        |=> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
        else $error("Entry count did not advance after a push.");

    a_no_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !(i_cmd.wr_en && i_cmd.rd_en))
        else $error("Memory write and read requested together.");

    a_valid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_res_status == ST_OK))
        else $error("Valid data reported with an error status.");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the indexed queue: a directed table, then random requests.
`timescale 1ns / 100ps

module tb_top
    import deq_pkg::*;
();

    localparam int DEPTH      = DEPTH_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_DIRECTED = 24;
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct {
        logic signed [WORD_W-1:0] data;
        logic                     data_valid;
        t_status                  status;
        logic        [OCC_W-1:0]  occupancy;
    } t_deq_result;

    typedef struct {
        t_action                  act;
        logic signed [WORD_W-1:0] val;
        logic        [POS_W-1:0]  pos;
        bit                       pinned;
        logic signed [WORD_W-1:0] w_data;
        logic                     w_valid;
        t_status                  w_status;
        logic        [OCC_W-1:0]  w_occ;
    } t_dir_row;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_ready;
    logic        [ACT_W-1:0]  i_action     = '0;
    logic signed [WORD_W-1:0] i_value      = '0;
    logic        [POS_W-1:0]  i_position   = '0;
    logic                     o_out_valid;
    logic                     i_out_ready  = 1'b0;
    logic signed [WORD_W-1:0] o_data;
    logic                     o_data_valid;
    logic        [STAT_W-1:0] o_status;
    logic        [OCC_W-1:0]  o_occupancy;

    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int                       shadow_head  = 0;
    int                       shadow_count = 0;

    t_deq_result pending_results [$];
    t_dir_row    dir_tab [N_DIRECTED];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    int          seq_no      = 0;
    bit          quiet       = 1'b0;

    double_ended_queue_indexed #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_data_valid(o_data_valid),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_deq_result deq_apply(t_action a, logic signed [WORD_W-1:0] v,
                                              logic [POS_W-1:0] p);
        t_deq_result r;
        r.data       = '0;
        r.data_valid = 1'b0;
        r.status     = ST_OK;
        case (a)
            ACT_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_words[(shadow_head + shadow_count) % DEPTH] = v;
                    shadow_count++;
                end
            end
            ACT_POP_BACK: begin
                if (shadow_count == 0) r.status = ST_EMPTY;
                else shadow_count--;
            end
            ACT_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_words[shadow_head] = v;
                    shadow_count++;
                end
            end
            ACT_POP_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                end
            end
            ACT_READ_FRONT: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data       = shadow_words[shadow_head];
                    r.data_valid = 1'b1;
                end
            end
            ACT_READ_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data       = shadow_words[(shadow_head + shadow_count - 1) % DEPTH];
                    r.data_valid = 1'b1;
                end
            end
            ACT_READ_POS: begin
                if (int'(p) >= shadow_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.data       = shadow_words[(shadow_head + int'(p)) % DEPTH];
                    r.data_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic void note_expected(t_deq_result e);
        pending_results.insert(pending_results.size(), e);
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(0, 19))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, DEPTH - 1));
        return POS_W'($urandom_range(0, (shadow_count >= DEPTH) ? DEPTH - 1 : shadow_count));
    endfunction

    task automatic send_request(t_action a, logic signed [WORD_W-1:0] v, logic [POS_W-1:0] p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= a;
        i_value    <= v;
        i_position <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic issue(t_action a, logic signed [WORD_W-1:0] v, logic [POS_W-1:0] p);
        quiet = (seq_no % 250) < 50;
        seq_no++;
        send_request(a, v, p);
        note_expected(deq_apply(a, v, p));
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 2) == 0) begin
            stall_left  <= idle_len() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: data %h valid %b status %0d occ %0d",
                             o_data, o_data_valid, o_status, o_occupancy);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_data !== want.data || o_data_valid !== want.data_valid ||
                    o_status !== want.status || o_occupancy !== want.occupancy) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp data %h valid %b status %0d occ %0d",
                                 want.data, want.data_valid, want.status, want.occupancy,
                                 ", got data %h valid %b status %0d occ %0d",
                                 o_data, o_data_valid, o_status, o_occupancy);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_deq_result got;
        t_action     a;
        int          r;
        dir_tab = '{
            '{ACT_READ_FRONT, '0, 10'd0, 1'b1, '0, 1'b0, ST_EMPTY, 11'd0},
            '{ACT_READ_BACK, '0, 10'd0, 1'b1, '0, 1'b0, ST_EMPTY, 11'd0},
            '{ACT_POP_BACK, '0, 10'd0, 1'b1, '0, 1'b0, ST_EMPTY, 11'd0},
            '{ACT_POP_FRONT, '0, 10'd0, 1'b1, '0, 1'b0, ST_EMPTY, 11'd0},
            '{ACT_READ_POS, '0, 10'd0, 1'b1, '0, 1'b0, ST_RANGE, 11'd0},
            '{ACT_READ_POS, '0, 10'd1023, 1'b1, '0, 1'b0, ST_RANGE, 11'd0},
            '{ACT_PUSH_BACK, WORD_MAX, 10'd0, 1'b1, '0, 1'b0, ST_OK, 11'd1},
            '{ACT_READ_FRONT, '0, 10'd0, 1'b1, WORD_MAX, 1'b1, ST_OK, 11'd1},
            '{ACT_PUSH_FRONT, WORD_MIN, 10'd1023, 1'b1, '0, 1'b0, ST_OK, 11'd2},
            '{ACT_READ_FRONT, '0, 10'd0, 1'b1, WORD_MIN, 1'b1, ST_OK, 11'd2},
            '{ACT_READ_BACK, '0, 10'd0, 1'b1, WORD_MAX, 1'b1, ST_OK, 11'd2},
            '{ACT_READ_POS, '0, 10'd0, 1'b1, WORD_MIN, 1'b1, ST_OK, 11'd2},
            '{ACT_READ_POS, '0, 10'd1, 1'b1, WORD_MAX, 1'b1, ST_OK, 11'd2},
            '{ACT_READ_POS, '0, 10'd2, 1'b1, '0, 1'b0, ST_RANGE, 11'd2},
            '{ACT_PUSH_BACK, '1, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_PUSH_FRONT, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_READ_POS, '0, 10'd3, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_READ_BACK, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_POP_FRONT, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_POP_BACK, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_READ_POS, '0, 10'd1023, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_POP_FRONT, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_POP_BACK, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0},
            '{ACT_POP_FRONT, '0, 10'd0, 1'b0, '0, 1'b0, ST_OK, 11'd0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(dir_tab[i].act, dir_tab[i].val, dir_tab[i].pos);
            got = deq_apply(dir_tab[i].act, dir_tab[i].val, dir_tab[i].pos);
            if (dir_tab[i].pinned) begin
                got.data       = dir_tab[i].w_data;
                got.data_valid = dir_tab[i].w_valid;
                got.status     = dir_tab[i].w_status;
                got.occupancy  = dir_tab[i].w_occ;
            end
            note_expected(got);
        end

        // Low occupancy: a random walk that keeps hitting the empty queue.
        for (int i = 0; i < 30; i++) begin
            a = t_action'($urandom_range(0, 6));
            issue(a, random_word(), pick_position());
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);

        // Push-heavy stream until the queue is full, then work at the full boundary.
        while (shadow_count < DEPTH) begin
            r = $urandom_range(0, 99);
            if (r < 49) a = ACT_PUSH_BACK;
            else if (r < 98) a = ACT_PUSH_FRONT;
            else a = t_action'($urandom_range(0, 6));
            issue(a, random_word(), pick_position());
        end
        for (int i = 0; i < 20; i++) begin
            a = t_action'($urandom_range(0, 6));
            issue(a, random_word(), pick_position());
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue_indexed.sv
tb/tb_top.sv
